// ----- rtl/priority_task_list_allocator_assert.svh -----
// Assertion macros for the allocator RTL
`ifndef PRIORITY_TASK_LIST_ALLOCATOR_ASSERT_SVH
`define PRIORITY_TASK_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define PTLA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptla: check failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define PTLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptla: check failed");

`endif

// ----- rtl/ptla_pkg.sv -----
// Shared constants, codes and control types of the task list allocator
package ptla_pkg;

  localparam int unsigned ARENA_BYTES = 16384;
  localparam int unsigned MAX_TASKS   = 32;
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned OFS_W       = 14;
  localparam int unsigned FP_W        = 15;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned PRIO_W      = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned THR_W       = 15;
  localparam int unsigned THR_RESET   = 256;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_SETPRI = 3'd2;
  localparam logic [OP_W-1:0] OP_RUN    = 3'd3;
  localparam logic [OP_W-1:0] OP_KEEP   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_RESP  = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_RELOC = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_NOSLOT  = 3'd2;
  localparam logic [2:0] ST_NOTUSED = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  // Read address select
  localparam logic [1:0] RD_SLOT = 2'd0;
  localparam logic [1:0] RD_CUR  = 2'd1;
  localparam logic [1:0] RD_BEST = 2'd2;

  // Result field source
  localparam logic [1:0] SRC_ZERO  = 2'd0;
  localparam logic [1:0] SRC_READ  = 2'd1;
  localparam logic [1:0] SRC_RELOC = 2'd2;

  // Datapath commands, one cycle each
  typedef struct packed {
    logic       latch;
    logic [1:0] rd_sel;
    logic       alloc;
    logic       kill;
    logic       set_prio;
    logic       unlink;
    logic       ins_empty;
    logic       keep_one;
    logic       clear;
    logic       walk_start;
    logic       walk_step;
    logic       link_a;
    logic       link_b;
    logic       run_next;
    logic       cmp_init;
    logic       scan_step;
    logic       place;
    logic       cmp_end;
    logic       emit;
    logic [1:0] emit_kind;
    logic [2:0] emit_status;
    logic [1:0] emit_src;
    logic       finish;
  } cmd_t;

  // Datapath status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            slot_live;
    logic            nospace;
    logic            nofree;
    logic            nonempty;
    logic            alone;
    logic            walk_done;
    logic            run_wrap;
    logic            need_compact;
    logic            scan_end;
    logic            found;
    logic            moved;
    logic            out_free;
    logic            hold_valid;
  } sts_t;

  // One result item
  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        status;
    logic [SLOT_W-1:0] task_slot;
    logic [OFS_W-1:0]  block_offset;
    logic [OFS_W-1:0]  old_offset;
    logic [OFS_W-1:0]  block_size;
    logic [FP_W-1:0]   bytes_in_use;
    logic [CNT_W-1:0]  task_count;
    logic              last;
  } rec_t;

endpackage

// ----- rtl/ptla_dp.sv -----
// Datapath: slot tables, list links, bump pointer, compaction scan, result staging
module ptla_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ptla_pkg::OP_W-1:0]     op_i,
  input  logic [ptla_pkg::SLOT_W-1:0]   slot_i,
  input  logic [ptla_pkg::OFS_W-1:0]    size_bytes_i,
  input  logic signed [ptla_pkg::PRIO_W-1:0] priority_req_i,
  input  logic [ptla_pkg::THR_W-1:0]    thr_i,
  input  ptla_pkg::cmd_t                cmd_i,
  output ptla_pkg::sts_t                sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output ptla_pkg::rec_t                out_rec_o
);
  import ptla_pkg::*;

  // Slot tables
  logic [PRIO_W-1:0] prio_q [MAX_TASKS];
  logic [OFS_W-1:0]  size_q [MAX_TASKS];
  logic [OFS_W-1:0]  ofs_q  [MAX_TASKS];
  logic [SLOT_W-1:0] next_q [MAX_TASKS];
  logic [SLOT_W-1:0] prev_q [MAX_TASKS];
  logic [MAX_TASKS-1:0] live_q;
  logic [MAX_TASKS-1:0] done_q;

  // Item and walk registers
  logic [OP_W-1:0]   op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [OFS_W-1:0]  req_size_q;
  logic [PRIO_W-1:0] req_prio_q;
  logic [SLOT_W-1:0] cur_q;
  logic [SLOT_W-1:0] ins_prev_q;
  logic [SLOT_W-1:0] ins_next_q;
  logic [SLOT_W-1:0] best_q;
  logic [OFS_W-1:0]  best_ofs_q;
  logic              found_q;
  logic [FP_W-1:0]   dest_q;

  // Global state
  logic [SLOT_W-1:0] head_q;
  logic              nonempty_q;
  logic [FP_W-1:0]   fp_q;
  logic [FP_W-1:0]   bytes_q;
  logic [CNT_W-1:0]  count_q;

  // Result staging
  rec_t hold_q;
  logic hold_valid_q;
  rec_t out_q;
  logic out_valid_q;

  logic [SLOT_W-1:0] raddr;
  logic [PRIO_W-1:0] rd_prio;
  logic [OFS_W-1:0]  rd_size;
  logic [OFS_W-1:0]  rd_ofs;
  logic [SLOT_W-1:0] rd_next;
  logic [SLOT_W-1:0] rd_prev;
  logic [SLOT_W-1:0] free_slot;
  logic              nofree;
  logic [FP_W:0]     fp_sum;
  logic [FP_W:0]     room;
  logic              less;
  logic              nxt_head;
  logic              cand;
  logic              moved;
  logic              out_free;
  logic              push;
  rec_t              rec_new;

  // Select the shared read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_CUR:  raddr = cur_q;
      RD_BEST: raddr = best_q;
      default: raddr = slot_q;
    endcase
  end

  assign rd_prio = prio_q[raddr];
  assign rd_size = size_q[raddr];
  assign rd_ofs  = ofs_q[raddr];
  assign rd_next = next_q[raddr];
  assign rd_prev = prev_q[raddr];

  // Find the lowest dead slot
  always_comb begin
    free_slot = '0;
    nofree    = 1'b1;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_slot = SLOT_W'(i);
        nofree    = 1'b0;
      end
    end
  end

  assign fp_sum   = {1'b0, fp_q} + (FP_W + 1)'(req_size_q);
  assign room     = (FP_W + 1)'(ARENA_BYTES) - {1'b0, fp_q};
  assign less     = $signed(req_prio_q) < $signed(rd_prio);
  assign nxt_head = (rd_next == head_q);
  assign cand     = live_q[cur_q] && !done_q[cur_q] && (!found_q || rd_ofs < best_ofs_q);
  assign moved    = (rd_ofs != dest_q[OFS_W-1:0]);
  assign out_free = !out_valid_q || out_ready_i;
  assign push     = (cmd_i.emit && hold_valid_q) || cmd_i.finish;

  // Status to the controller
  always_comb begin
    sts_o.op           = op_q;
    sts_o.slot_live    = live_q[slot_q];
    sts_o.nospace      = (req_size_q == '0) || (fp_sum >= (FP_W + 1)'(ARENA_BYTES));
    sts_o.nofree       = nofree;
    sts_o.nonempty     = nonempty_q;
    sts_o.alone        = (slot_q == head_q) && (rd_next == slot_q);
    sts_o.walk_done    = less || nxt_head;
    sts_o.run_wrap     = nxt_head;
    sts_o.need_compact = room < (FP_W + 1)'(thr_i);
    sts_o.scan_end     = (cur_q == SLOT_W'(MAX_TASKS - 1));
    sts_o.found        = found_q;
    sts_o.moved        = moved;
    sts_o.out_free     = out_free;
    sts_o.hold_valid   = hold_valid_q;
  end

  // Build the next result record
  always_comb begin
    rec_new              = '0;
    rec_new.kind         = cmd_i.emit_kind;
    rec_new.status       = cmd_i.emit_status;
    rec_new.bytes_in_use = bytes_q;
    rec_new.task_count   = count_q;
    case (cmd_i.emit_src)
      SRC_READ: begin
        rec_new.task_slot    = raddr;
        rec_new.block_offset = rd_ofs;
        rec_new.block_size   = rd_size;
      end
      SRC_RELOC: begin
        rec_new.task_slot    = raddr;
        rec_new.block_offset = dest_q[OFS_W-1:0];
        rec_new.old_offset   = rd_ofs;
        rec_new.block_size   = rd_size;
      end
      default: ;
    endcase
  end

  // Hold item fields and walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q       <= op_i;
      slot_q     <= slot_i;
      req_size_q <= size_bytes_i;
      req_prio_q <= priority_req_i;
    end else if (cmd_i.alloc) begin
      slot_q <= free_slot;
    end
    if (cmd_i.walk_start) begin
      cur_q <= head_q;
    end else if (cmd_i.walk_step && !less && !nxt_head) begin
      cur_q <= rd_next;
    end else if (cmd_i.run_next) begin
      cur_q <= rd_next;
    end else if (cmd_i.cmp_init || cmd_i.place) begin
      cur_q <= '0;
    end else if (cmd_i.scan_step) begin
      cur_q <= cur_q + SLOT_W'(1);
    end
    if (cmd_i.walk_step && less) begin
      ins_prev_q <= rd_prev;
      ins_next_q <= cur_q;
    end else if (cmd_i.walk_step && nxt_head) begin
      ins_prev_q <= cur_q;
      ins_next_q <= rd_next;
    end
    if (cmd_i.scan_step && cand) begin
      best_q     <= cur_q;
      best_ofs_q <= rd_ofs;
    end
    if (cmd_i.cmp_init) begin
      dest_q <= '0;
      done_q <= '0;
    end else if (cmd_i.place) begin
      dest_q         <= dest_q + FP_W'(rd_size);
      done_q[best_q] <= 1'b1;
    end
  end

  // Write the slot tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      size_q[free_slot] <= req_size_q;
      ofs_q[free_slot]  <= fp_q[OFS_W-1:0];
      prio_q[free_slot] <= req_prio_q;
    end else if (cmd_i.set_prio) begin
      prio_q[slot_q] <= req_prio_q;
    end else if (cmd_i.place && moved) begin
      ofs_q[best_q] <= dest_q[OFS_W-1:0];
    end
    if (cmd_i.unlink && !(slot_q == head_q && rd_next == slot_q)) begin
      next_q[rd_prev] <= rd_next;
      prev_q[rd_next] <= rd_prev;
    end else if (cmd_i.ins_empty) begin
      next_q[slot_q] <= slot_q;
      prev_q[slot_q] <= slot_q;
    end else if (cmd_i.link_a) begin
      next_q[slot_q] <= ins_next_q;
      prev_q[slot_q] <= ins_prev_q;
    end else if (cmd_i.link_b) begin
      next_q[ins_prev_q] <= slot_q;
      prev_q[ins_next_q] <= slot_q;
    end
  end

  // Update list head, counters and live bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q     <= '0;
      head_q     <= '0;
      nonempty_q <= 1'b0;
      fp_q       <= '0;
      bytes_q    <= '0;
      count_q    <= '0;
      found_q    <= 1'b0;
    end else begin
      if (cmd_i.alloc) begin
        live_q[free_slot] <= 1'b1;
        fp_q              <= fp_sum[FP_W-1:0];
        bytes_q           <= bytes_q + FP_W'(req_size_q);
        count_q           <= count_q + CNT_W'(1);
      end else if (cmd_i.kill) begin
        live_q[slot_q] <= 1'b0;
        bytes_q        <= bytes_q - FP_W'(rd_size);
        count_q        <= count_q - CNT_W'(1);
      end else if (cmd_i.keep_one) begin
        live_q  <= MAX_TASKS'(1) << slot_q;
        bytes_q <= FP_W'(rd_size);
        count_q <= CNT_W'(1);
      end else if (cmd_i.clear) begin
        live_q  <= '0;
        fp_q    <= '0;
        bytes_q <= '0;
        count_q <= '0;
      end else if (cmd_i.cmp_end) begin
        fp_q <= dest_q;
      end
      if (cmd_i.unlink) begin
        if (slot_q == head_q && rd_next == slot_q) begin
          nonempty_q <= 1'b0;
        end else if (slot_q == head_q) begin
          head_q <= rd_next;
        end
      end else if (cmd_i.ins_empty) begin
        head_q     <= slot_q;
        nonempty_q <= 1'b1;
      end else if (cmd_i.walk_step && less && cur_q == head_q) begin
        head_q <= slot_q;
      end else if (cmd_i.clear) begin
        head_q     <= '0;
        nonempty_q <= 1'b0;
      end
      if (cmd_i.cmp_init || cmd_i.place) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_step && cand) begin
        found_q <= 1'b1;
      end
    end
  end

  // Stage results: hold the newest, transfer the older one out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        hold_valid_q <= 1'b1;
      end else if (cmd_i.finish) begin
        hold_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      hold_q <= rec_new;
    end
    // Mark the final result of the item
    if (cmd_i.finish) begin
      out_q <= {hold_q[$bits(rec_t)-1:1], 1'b1};
    end else if (push) begin
      out_q <= hold_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_q;

endmodule

// ----- rtl/ptla_ctrl.sv -----
// Controller: sequences each operation over the datapath
module ptla_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ptla_pkg::sts_t sts_i,
  output ptla_pkg::cmd_t cmd_o
);
  import ptla_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DISP      = 5'd1;
  localparam logic [4:0] S_RESP_ERR  = 5'd2;
  localparam logic [4:0] S_RESP_ZERO = 5'd3;
  localparam logic [4:0] S_RESP_OK   = 5'd4;
  localparam logic [4:0] S_FIN       = 5'd5;
  localparam logic [4:0] S_UNLINK    = 5'd6;
  localparam logic [4:0] S_SP_CHK    = 5'd7;
  localparam logic [4:0] S_INS_CHK   = 5'd8;
  localparam logic [4:0] S_WALK      = 5'd9;
  localparam logic [4:0] S_LINK_A    = 5'd10;
  localparam logic [4:0] S_LINK_B    = 5'd11;
  localparam logic [4:0] S_RUN_EMIT  = 5'd12;
  localparam logic [4:0] S_CMP_CHK   = 5'd13;
  localparam logic [4:0] S_SCAN      = 5'd14;
  localparam logic [4:0] S_PICK      = 5'd15;
  localparam logic [4:0] S_RUN_END   = 5'd16;

  logic [4:0] state_q, state_d;
  logic [2:0] err_q, err_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_SLOT;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.op)
          OP_CREATE: begin
            if (sts_i.nospace) begin
              err_d   = ST_NOSPACE;
              state_d = S_RESP_ERR;
            end else if (sts_i.nofree) begin
              err_d   = ST_NOSLOT;
              state_d = S_RESP_ERR;
            end else begin
              cmd_o.alloc = 1'b1;
              state_d     = S_INS_CHK;
            end
          end
          OP_REMOVE: begin
            if (!sts_i.slot_live) begin
              err_d   = ST_NOTUSED;
              state_d = S_RESP_ERR;
            end else begin
              cmd_o.kill = 1'b1;
              state_d    = S_UNLINK;
            end
          end
          OP_SETPRI: begin
            if (!sts_i.slot_live) begin
              err_d   = ST_NOTUSED;
              state_d = S_RESP_ERR;
            end else begin
              cmd_o.set_prio = 1'b1;
              state_d        = S_SP_CHK;
            end
          end
          OP_RUN: begin
            if (sts_i.nonempty) begin
              cmd_o.walk_start = 1'b1;
              state_d          = S_RUN_EMIT;
            end else begin
              state_d = S_CMP_CHK;
            end
          end
          OP_KEEP: begin
            if (!sts_i.slot_live) begin
              err_d   = ST_NOTUSED;
              state_d = S_RESP_ERR;
            end else begin
              cmd_o.keep_one  = 1'b1;
              cmd_o.ins_empty = 1'b1;
              state_d         = S_RESP_OK;
            end
          end
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = S_RESP_ZERO;
          end
          default: state_d = S_RESP_ZERO;
        endcase
      end
      S_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d      = (sts_i.op == OP_REMOVE) ? S_RESP_OK : S_INS_CHK;
      end
      S_SP_CHK: begin
        state_d = sts_i.alone ? S_RESP_OK : S_UNLINK;
      end
      S_INS_CHK: begin
        if (!sts_i.nonempty) begin
          cmd_o.ins_empty = 1'b1;
          state_d         = S_RESP_OK;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.rd_sel    = RD_CUR;
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_LINK_A;
        end
      end
      S_LINK_A: begin
        cmd_o.link_a = 1'b1;
        state_d      = S_LINK_B;
      end
      S_LINK_B: begin
        cmd_o.link_b = 1'b1;
        state_d      = S_RESP_OK;
      end
      S_RUN_EMIT: begin
        cmd_o.rd_sel = RD_CUR;
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_RUN;
          cmd_o.emit_src  = SRC_READ;
          cmd_o.run_next  = 1'b1;
          if (sts_i.run_wrap) begin
            state_d = S_CMP_CHK;
          end
        end
      end
      S_CMP_CHK: begin
        if (sts_i.need_compact) begin
          cmd_o.cmp_init = 1'b1;
          state_d        = S_SCAN;
        end else begin
          state_d = S_RUN_END;
        end
      end
      S_SCAN: begin
        cmd_o.rd_sel    = RD_CUR;
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_end) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.rd_sel = RD_BEST;
        if (!sts_i.found) begin
          cmd_o.cmp_end = 1'b1;
          state_d       = S_RUN_END;
        end else if (!sts_i.moved) begin
          cmd_o.place = 1'b1;
          state_d     = S_SCAN;
        end else if (sts_i.out_free) begin
          cmd_o.place     = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_RELOC;
          cmd_o.emit_src  = SRC_RELOC;
          state_d         = S_SCAN;
        end
      end
      S_RUN_END: begin
        if (sts_i.hold_valid) begin
          state_d = S_FIN;
        end else begin
          err_d   = ST_EMPTY;
          state_d = S_RESP_ERR;
        end
      end
      S_RESP_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_kind   = KIND_RESP;
          cmd_o.emit_status = err_q;
          cmd_o.emit_src    = SRC_ZERO;
          state_d           = S_FIN;
        end
      end
      S_RESP_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_RESP;
          cmd_o.emit_src  = SRC_ZERO;
          state_d         = S_FIN;
        end
      end
      S_RESP_OK: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_RESP;
          cmd_o.emit_src  = SRC_READ;
          state_d         = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

endmodule

// ----- rtl/priority_task_list_allocator.sv -----
// Create and set priority walk the list from the head to find the insertion point (set priority
// leaves the only task in place); create into an empty list does not walk. Run emits each live
// task in list order and, if the free room is below the threshold, compacts with repeated
// address scans over all slots. A stalled output holds any operation that waits to emit.
// One item at a time: the next transfer is taken once the controller is back in idle after the last result is staged.
// Reset clears list, counters and live bits at once; threshold resets to 256.
module priority_task_list_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ptla_pkg::OP_W-1:0]          op_i,
  input  logic [ptla_pkg::SLOT_W-1:0]        slot_i,
  input  logic [ptla_pkg::OFS_W-1:0]         size_bytes_i,
  input  logic signed [ptla_pkg::PRIO_W-1:0] priority_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         kind_o,
  output logic [2:0]                         status_o,
  output logic [ptla_pkg::SLOT_W-1:0]        task_slot_o,
  output logic [ptla_pkg::OFS_W-1:0]         block_offset_o,
  output logic [ptla_pkg::OFS_W-1:0]         old_offset_o,
  output logic [ptla_pkg::OFS_W-1:0]         block_size_o,
  output logic [ptla_pkg::FP_W-1:0]          bytes_in_use_o,
  output logic [ptla_pkg::CNT_W-1:0]         task_count_o,
  output logic                               last_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ptla_pkg::*;
`include "priority_task_list_allocator_assert.svh"

  logic [THR_W-1:0] thr_q;
  cmd_t cmd;
  sts_t sts;
  rec_t rec;

  // Write the compaction threshold on an APB write with paddr[2] low
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(THR_RESET);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - THR_W){1'b0}}, thr_q};

  ptla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptla_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op_i),
    .slot_i         (slot_i),
    .size_bytes_i   (size_bytes_i),
    .priority_req_i (priority_req_i),
    .thr_i          (thr_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_rec_o      (rec)
  );

  assign kind_o         = rec.kind;
  assign status_o       = rec.status;
  assign task_slot_o    = rec.task_slot;
  assign block_offset_o = rec.block_offset;
  assign old_offset_o   = rec.old_offset;
  assign block_size_o   = rec.block_size;
  assign bytes_in_use_o = rec.bytes_in_use;
  assign task_count_o   = rec.task_count;
  assign last_o         = rec.last;

  `PTLA_ASSERT_IMP(a_reloc_moves, out_valid_o && kind_o == KIND_RELOC, old_offset_o != block_offset_o)
  `PTLA_ASSERT_IMP(a_count_max, out_valid_o, task_count_o <= CNT_W'(MAX_TASKS))
  `PTLA_ASSERT_IMP(a_bytes_max, out_valid_o, bytes_in_use_o < FP_W'(ARENA_BYTES))
  `PTLA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

endmodule
